// File: rtl/lspv_pkg.sv
`timescale 1ns / 1ps

package lspv_pkg;

  // Fixed number formats of the voice.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_BITS   = 16;
  localparam int MAX_FRAMES  = 65536;
  localparam int POS_BITS    = FRAC_BITS + 18;
  localparam int WORK_BITS   = POS_BITS + 2;
  localparam int CFG_BITS    = 20;

  // Largest start fraction, 0.999 in Q0.16.
  localparam logic [FRAC_BITS-1:0] START_LIMIT = FRAC_BITS'((999 << FRAC_BITS) / 1000);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FRAMES_IN_USE    = 3'd0,
    REG_SAMPLE_IS_STEREO = 3'd1,
    REG_PLAY_START       = 3'd2,
    REG_PLAY_END         = 3'd3,
    REG_LOOP_BEGIN       = 3'd4,
    REG_LOOP_FINISH      = 3'd5,
    REG_LOOP_KIND        = 3'd6,
    REG_PLAYBACK_RATE    = 3'd7
  } reg_index_t;

  localparam logic [1:0] LOOP_NONE     = 2'd0;
  localparam logic [1:0] LOOP_FORWARD  = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;
  localparam logic [1:0] LOOP_SUSTAIN  = 2'd3;

  typedef struct packed {
    logic [16:0] frames_in_use;
    logic        sample_is_stereo;
    logic [15:0] play_start;
    logic [16:0] play_end;
    logic [15:0] loop_begin;
    logic [16:0] loop_finish;
    logic [1:0]  loop_kind;
    logic [19:0] playback_rate;
  } cfg_t;

  // Register values after reset: rate at 1.0, everything else zero.
  localparam cfg_t CFG_RESET = '{17'd0, 1'b0, 16'd0, 17'd0, 16'd0, 17'd0, 2'd0, 20'd65536};

  typedef struct packed {
    cmd_t                          kind;
    logic [ADDR_BITS-1:0]          load_index;
    logic signed [SAMPLE_BITS-1:0] load_left;
    logic signed [SAMPLE_BITS-1:0] load_right;
    logic [15:0]                   start_fraction;
    logic [19:0]                   pitch_step;
  } item_t;

endpackage

// File: rtl/lspv_ram.sv
`timescale 1ns / 1ps

module lspv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lspv_front.sv
`timescale 1ns / 1ps

module lspv_front import lspv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      incoming;

  // Unpack the incoming transaction into a command record.
  always_comb begin
    incoming.kind           = cmd_t'(s_tuser);
    incoming.load_index     = s_tdata[15:0];
    incoming.load_left      = s_tdata[31:16];
    incoming.load_right     = s_tdata[47:32];
    incoming.start_fraction = s_tdata[63:48];
    incoming.pitch_step     = s_tdata[83:64];
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // Two-entry queue between the input side and the executor.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/lspv_back.sv
`timescale 1ns / 1ps

module lspv_back import lspv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [0:0]  m_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_ST_MUL, S_ST_ADD, S_TK_CHK, S_TK_RD0, S_TK_RD1,
    S_TK_MUL, S_TK_SUM, S_TK_LOOP, S_TK_MOD, S_EMIT
  } state_t;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  state_t                        state;
  item_t                         item;
  logic signed [POS_BITS-1:0]    pos;
  logic                          backward;
  logic                          released;
  logic                          done;
  logic                          loops;
  logic [ADDR_BITS-1:0]          idx;
  logic [FRAC_BITS-1:0]          frac;
  logic [32:0]                   span_prod;
  logic [23:0]                   adv;
  logic [31:0]                   sample_a;
  logic signed [33:0]            prod_l;
  logic signed [33:0]            prod_r;
  logic signed [WORK_BITS-1:0]   wpos;
  logic [34:0]                   div_num;
  logic [33:0]                   rem;
  logic [5:0]                    div_cnt;
  logic [SAMPLE_BITS-1:0]        res_l;
  logic [SAMPLE_BITS-1:0]        res_r;
  logic [SAMPLE_BITS-1:0]        out_l;
  logic [SAMPLE_BITS-1:0]        out_r;
  logic                          out_fin;

  logic [16:0]                   frames;
  logic [16:0]                   last;
  logic [16:0]                   span;
  logic [FRAC_BITS-1:0]          frac_clamp;
  logic                          loops_c;
  logic [33:0]                   start_sum;
  logic [39:0]                   adv_prod;
  logic signed [WORK_BITS-1:0]   ls;
  logic signed [WORK_BITS-1:0]   le;
  logic [32:0]                   len;
  logic [34:0]                   rem_sh;
  logic [33:0]                   rem_new;
  logic signed [16:0]            diff_l;
  logic signed [16:0]            diff_r;
  logic signed [17:0]            sum_l;
  logic signed [17:0]            sum_r;
  logic signed [WORK_BITS-1:0]   pos_w;
  logic signed [WORK_BITS-1:0]   adv_w;
  logic signed [WORK_BITS-1:0]   end_mark;
  logic [31:0]                   rdata;
  logic [ADDR_BITS-1:0]          raddr;
  logic                          ram_we;

  function automatic logic signed [POS_BITS-1:0] sat_pos(logic signed [WORK_BITS-1:0] v);
    if (v > WORK_BITS'(POS_MAX)) begin
      return POS_MAX;
    end else if (v < WORK_BITS'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[POS_BITS-1:0];
  endfunction

  // Region and loop decode from the configuration.
  always_comb begin
    frames = (cfg.frames_in_use > 17'(MAX_FRAMES)) ? 17'(MAX_FRAMES) : cfg.frames_in_use;
    last = (cfg.play_end != 17'd0 && cfg.play_end <= frames) ? cfg.play_end : frames;
    span = (last > {1'b0, cfg.play_start}) ? last - {1'b0, cfg.play_start} : 17'd0;
    frac_clamp = (item.start_fraction > START_LIMIT) ? START_LIMIT : item.start_fraction;
    loops_c = (cfg.loop_kind != LOOP_NONE)
           && (cfg.loop_finish > ({1'b0, cfg.loop_begin} + 17'd1))
           && (cfg.loop_finish <= frames)
           && !(cfg.loop_kind == LOOP_SUSTAIN && released);
    start_sum = {2'b00, cfg.play_start, {FRAC_BITS{1'b0}}} + {1'b0, span_prod};
    adv_prod = item.pitch_step * cfg.playback_rate;
    ls = {4'b0000, cfg.loop_begin, {FRAC_BITS{1'b0}}};
    le = {3'b000, cfg.loop_finish, {FRAC_BITS{1'b0}}};
    len = 33'(le - ls);
    end_mark = {3'b000, last - 17'd1, {FRAC_BITS{1'b0}}};
    pos_w = WORK_BITS'(pos);
    adv_w = {{(WORK_BITS-24){1'b0}}, adv};
  end

  // Interpolation and remainder datapath.
  always_comb begin
    diff_l = 17'(signed'(rdata[15:0])) - 17'(signed'(sample_a[15:0]));
    diff_r = 17'(signed'(rdata[31:16])) - 17'(signed'(sample_a[31:16]));
    sum_l = 18'(signed'(sample_a[15:0])) + prod_l[33:16];
    sum_r = 18'(signed'(sample_a[31:16])) + prod_r[33:16];
    rem_sh = {rem, div_num[34]};
    rem_new = (rem_sh >= {2'b00, len}) ? 34'(rem_sh - {2'b00, len}) : rem_sh[33:0];
  end

  // Sample memory: right channel in the upper half, left in the lower.
  assign ram_we  = (state == S_IDLE) && q_valid && (q_item.kind == CMD_LOAD);
  assign raddr   = (state == S_TK_RD1) ? idx + ADDR_BITS'(1) : idx;
  assign q_ready = (state == S_IDLE);

  lspv_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.load_index),
    .wdata ({q_item.load_right, q_item.load_left}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign m_tdata = {out_r, out_l};
  assign m_tuser = out_fin;

  // Command sequencer and voice state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      backward <= 1'b0;
      released <= 1'b0;
      done     <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            case (q_item.kind)
              CMD_START: begin
                done     <= 1'b0;
                backward <= 1'b0;
                released <= 1'b0;
                state    <= S_ST_MUL;
              end
              CMD_RELEASE: released <= 1'b1;
              CMD_TICK:    state <= S_TK_CHK;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_ST_MUL: begin
          span_prod <= span * frac_clamp;
          state     <= S_ST_ADD;
        end
        S_ST_ADD: begin
          pos   <= start_sum[33] ? POS_MAX : start_sum;
          state <= S_IDLE;
        end
        S_TK_CHK: begin
          res_l <= '0;
          res_r <= '0;
          loops <= loops_c;
          if (done) begin
            state <= S_EMIT;
          end else if (frames < 17'd2) begin
            done  <= 1'b1;
            state <= S_EMIT;
          end else if (pos < 0) begin
            idx   <= '0;
            frac  <= '0;
            state <= S_TK_RD0;
          end else if (pos[POS_BITS-1:FRAC_BITS] >= {1'b0, frames - 17'd1}) begin
            if (!loops_c) begin
              done  <= 1'b1;
              state <= S_EMIT;
            end else begin
              idx   <= cfg.loop_begin;
              frac  <= '0;
              pos   <= {2'b00, cfg.loop_begin, {FRAC_BITS{1'b0}}};
              state <= S_TK_RD0;
            end
          end else begin
            idx   <= pos[FRAC_BITS+ADDR_BITS-1:FRAC_BITS];
            frac  <= pos[FRAC_BITS-1:0];
            state <= S_TK_RD0;
          end
        end
        S_TK_RD0: begin
          adv   <= adv_prod[39:16];
          state <= S_TK_RD1;
        end
        S_TK_RD1: begin
          sample_a <= rdata;
          state    <= S_TK_MUL;
        end
        S_TK_MUL: begin
          prod_l <= diff_l * signed'({1'b0, frac});
          prod_r <= diff_r * signed'({1'b0, frac});
          state  <= S_TK_SUM;
        end
        S_TK_SUM: begin
          res_l <= sum_l[15:0];
          res_r <= cfg.sample_is_stereo ? sum_r[15:0] : sum_l[15:0];
          wpos  <= backward ? pos_w - adv_w : pos_w + adv_w;
          state <= S_TK_LOOP;
        end
        S_TK_LOOP: begin
          state <= S_EMIT;
          if (loops) begin
            if (cfg.loop_kind == LOOP_PINGPONG) begin
              if (wpos >= le) begin
                pos      <= sat_pos(le + le - wpos);
                backward <= 1'b1;
              end else if (wpos <= ls) begin
                pos      <= sat_pos(ls + ls - wpos);
                backward <= 1'b0;
              end else begin
                pos <= sat_pos(wpos);
              end
            end else if (wpos >= le) begin
              div_num <= 35'(wpos - ls);
              rem     <= '0;
              div_cnt <= 6'd35;
              state   <= S_TK_MOD;
            end else begin
              pos <= sat_pos(wpos);
            end
          end else begin
            if (wpos >= end_mark || wpos < 0) begin
              done <= 1'b1;
            end
            pos <= sat_pos(wpos);
          end
        end
        S_TK_MOD: begin
          // Restoring remainder, one dividend bit per cycle.
          rem     <= rem_new;
          div_num <= {div_num[33:0], 1'b0};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            pos   <= sat_pos(ls + WORK_BITS'(rem_new));
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_l    <= res_l;
            out_r    <= res_r;
            out_fin  <= done;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/looping_sample_playback_voice.sv
`timescale 1ns / 1ps
// Loads and releases are handled in the executor's idle state; a start adds a multiply and
// an add state; a tick reads, interpolates, advances and emits, going straight to emit when
// the voice is or becomes done before reading, while a forward or sustain loop wrap adds a
// bit-serial remainder. The executor takes no new item before it is through with the last;
// a two-entry queue and the output register let input and output stall independently.
// Reset (synchronous, active high) leaves the voice done, rate 1.0, other registers 0.

module looping_sample_playback_voice import lspv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // load_index, load_left, load_right, start_fraction, pitch_step
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_out, right_out
  output logic [0:0]  m_tuser,   // finished
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_FRAMES_IN_USE:    cfg.frames_in_use    <= cfg_data[16:0];
        REG_SAMPLE_IS_STEREO: cfg.sample_is_stereo <= cfg_data[0];
        REG_PLAY_START:       cfg.play_start       <= cfg_data[15:0];
        REG_PLAY_END:         cfg.play_end         <= cfg_data[16:0];
        REG_LOOP_BEGIN:       cfg.loop_begin       <= cfg_data[15:0];
        REG_LOOP_FINISH:      cfg.loop_finish      <= cfg_data[16:0];
        REG_LOOP_KIND:        cfg.loop_kind        <= cfg_data[1:0];
        REG_PLAYBACK_RATE:    cfg.playback_rate    <= cfg_data;
        default:              cfg.playback_rate    <= cfg.playback_rate;
      endcase
    end
  end

  lspv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lspv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/lspv_checker.sv
`timescale 1ns / 1ps

module lspv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [87:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_write,
  input logic [2:0]  cfg_index,
  input logic [19:0] cfg_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A waiting input transaction keeps its contents until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("waiting input changed");

  // Register writes carry a known index and value.
  a_cfg_known: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !$isunknown(cfg_index) && !$isunknown(cfg_data))
    else $error("register write with unknown index or data");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // The input queue is empty, and so ready, right after reset.
  a_reset_ready: assert property (@(posedge clk) $past(rst) |-> s_tready)
    else $error("input not ready after reset");

endmodule

bind looping_sample_playback_voice lspv_checker u_checker (.*);

// File: tb/voice_checker.sv
`timescale 1ns / 1ps

module voice_checker import lspv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,   // load_index, load_left, load_right, start_fraction, pitch_step
  input  logic [1:0]  s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // left_out, right_out
  input  logic [0:0]  m_tuser,   // finished
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          errors,
  output int          waiting,
  output int          checked
);

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               fin;
  } voice_out_t;

  localparam longint POS_LIM = longint'(1) << (POS_BITS - 1);

  // Predicted voice state and register copy.
  shortint    left_mem [MAX_FRAMES];
  shortint    right_mem[MAX_FRAMES];
  longint     pos;
  bit         backward;
  bit         released;
  bit         done;
  cfg_t       regs;
  voice_out_t tick_results[$];
  int         err_count;
  int         check_count;

  function automatic longint clamp_pos(longint p);
    if (p > POS_LIM - 1) return POS_LIM - 1;
    if (p < -POS_LIM) return -POS_LIM;
    return p;
  endfunction

  // Linear blend between two samples; the arithmetic shift rounds toward minus infinity.
  function automatic longint blend(shortint a, shortint b, longint f);
    return longint'(a) + (((longint'(b) - longint'(a)) * f) >>> FRAC_BITS);
  endfunction

  function automatic longint usable_frames();
    longint n;
    n = longint'(regs.frames_in_use);
    return (n > MAX_FRAMES) ? MAX_FRAMES : n;
  endfunction

  function automatic longint region_end(longint frames);
    longint pe;
    pe = longint'(regs.play_end);
    return (pe > 0 && pe <= frames) ? pe : frames;
  endfunction

  function automatic void start_voice(logic [15:0] frac);
    longint frames, last, span, f, ps;
    frames = usable_frames();
    last   = region_end(frames);
    ps     = longint'(regs.play_start);
    span   = (last > ps) ? last - ps : 0;
    f      = longint'(frac);
    if (f > longint'(START_LIMIT)) f = longint'(START_LIMIT);
    done     = 0;
    backward = 0;
    released = 0;
    pos      = clamp_pos((ps << FRAC_BITS) + span * f);
  endfunction

  function automatic voice_out_t tick_voice(logic [19:0] step);
    voice_out_t o;
    longint     frames, last, i, f, l, r, adv, ls, le, len;
    bit         loops;
    o.left  = '0;
    o.right = '0;
    o.fin   = 1'b1;
    if (done) return o;
    frames = usable_frames();
    if (frames < 2) begin
      done = 1;
      return o;
    end
    last  = region_end(frames);
    loops = regs.loop_kind != LOOP_NONE
            && longint'(regs.loop_finish) > longint'(regs.loop_begin) + 1
            && longint'(regs.loop_finish) <= frames
            && !(regs.loop_kind == LOOP_SUSTAIN && released);

    // Split the position into frame and fraction; negative reads frame zero.
    if (pos < 0) begin
      i = 0;
      f = 0;
    end else begin
      i = pos >>> FRAC_BITS;
      f = pos - (i << FRAC_BITS);
    end
    if (i >= frames - 1) begin
      if (!loops) begin
        done = 1;
        return o;
      end
      i   = longint'(regs.loop_begin);
      pos = i << FRAC_BITS;
      f   = 0;
    end
    l = blend(left_mem[i], left_mem[i + 1], f);
    if (regs.sample_is_stereo) r = blend(right_mem[i], right_mem[i + 1], f);
    else r = l;

    // Advance, then apply the loop or end rules.
    adv = (longint'(step) * longint'(regs.playback_rate)) >>> (32 - FRAC_BITS);
    pos = backward ? pos - adv : pos + adv;
    ls  = longint'(regs.loop_begin) << FRAC_BITS;
    le  = longint'(regs.loop_finish) << FRAC_BITS;
    if (loops) begin
      if (regs.loop_kind == LOOP_PINGPONG) begin
        if (pos >= le) begin
          pos      = le - (pos - le);
          backward = 1;
        end else if (pos <= ls) begin
          pos      = ls + (ls - pos);
          backward = 0;
        end
      end else if (pos >= le) begin
        len = le - ls;
        pos = pos - len * ((pos - ls) / len);
      end
    end else if (pos >= ((last - 1) << FRAC_BITS) || pos < 0) begin
      done = 1;
    end
    pos = clamp_pos(pos);

    o.left  = l[15:0];
    o.right = r[15:0];
    o.fin   = done;
    return o;
  endfunction

  always @(posedge clk) begin
    voice_out_t exp_out;
    if (rst) begin
      pos                = 0;
      backward           = 0;
      released           = 0;
      done               = 1;
      regs               = '0;
      regs.playback_rate = 20'd65536;
      tick_results.delete();
      err_count          = 0;
      check_count        = 0;
    end else begin
      // Result transactions are compared against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (tick_results.size() == 0) begin
          $error("unexpected result transaction left=%0d right=%0d finished=%0d",
                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser[0]);
          err_count++;
        end else begin
          exp_out = tick_results.pop_front();
          check_count++;
          if (m_tdata[15:0] !== exp_out.left) begin
            $error("left_out expected %0d actual %0d", exp_out.left, $signed(m_tdata[15:0]));
            err_count++;
          end
          if (m_tdata[31:16] !== exp_out.right) begin
            $error("right_out expected %0d actual %0d", exp_out.right,
                   $signed(m_tdata[31:16]));
            err_count++;
          end
          if (m_tuser[0] !== exp_out.fin) begin
            $error("finished expected %0d actual %0d", exp_out.fin, m_tuser[0]);
            err_count++;
          end
        end
      end

      // Register writes.
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_FRAMES_IN_USE:    regs.frames_in_use    = cfg_data[16:0];
          REG_SAMPLE_IS_STEREO: regs.sample_is_stereo = cfg_data[0];
          REG_PLAY_START:       regs.play_start       = cfg_data[15:0];
          REG_PLAY_END:         regs.play_end         = cfg_data[16:0];
          REG_LOOP_BEGIN:       regs.loop_begin       = cfg_data[15:0];
          REG_LOOP_FINISH:      regs.loop_finish      = cfg_data[16:0];
          REG_LOOP_KIND:        regs.loop_kind        = cfg_data[1:0];
          REG_PLAYBACK_RATE:    regs.playback_rate    = cfg_data[19:0];
          default: ;
        endcase
      end

      // Input transactions update the prediction.
      if (s_tvalid && s_tready) begin
        case (cmd_t'(s_tuser))
          CMD_LOAD: begin
            left_mem[s_tdata[15:0]]  = shortint'(s_tdata[31:16]);
            right_mem[s_tdata[15:0]] = shortint'(s_tdata[47:32]);
          end
          CMD_START:   start_voice(s_tdata[63:48]);
          CMD_RELEASE: released = 1;
          default:     tick_results.insert(tick_results.size(), tick_voice(s_tdata[83:64]));
        endcase
      end
    end
    errors  <= err_count;
    waiting <= tick_results.size();
    checked <= check_count;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lspv_pkg::*;

  localparam int LOADED   = 256;
  localparam int TAIL     = 60;
  localparam int LIMIT    = 800000;
  localparam int ITEMS    = 935;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  int errors;
  int waiting;
  int checked;
  int cycles;
  int sent;
  int n_load, n_start, n_release, n_tick, n_settings;
  int hold;
  bit calm;

  looping_sample_playback_voice u_dut (.*);

  voice_checker u_checker (.*);

  always #5 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int x;
    if (calm) return 0;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      m_tready <= 1'b0;
      hold--;
    end else begin
      m_tready <= 1'b1;
      hold = pick_gap();
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(cmd_t c, logic [15:0] idx, logic [15:0] l, logic [15:0] r,
                           logic [15:0] frac, logic [19:0] step);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {4'b0, step, frac, r, l, idx};
    do @(posedge clk); while (!s_tready);
    sent++;
    case (c)
      CMD_LOAD:    n_load++;
      CMD_START:   n_start++;
      CMD_RELEASE: n_release++;
      default:     n_tick++;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_step();
    case ($urandom_range(0, 19))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      2:       return 20'($urandom);
      default: return 20'($urandom_range(4096, 20'h30000));
    endcase
  endfunction

  task automatic load(logic [15:0] idx);
    send_item(CMD_LOAD, idx, rand_sample(), rand_sample(), 16'($urandom), 20'($urandom));
  endtask

  task automatic start(logic [15:0] frac);
    send_item(CMD_START, 16'($urandom), 16'($urandom), 16'($urandom), frac, 20'($urandom));
  endtask

  task automatic release_key();
    send_item(CMD_RELEASE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              20'($urandom));
  endtask

  task automatic tick(logic [19:0] step);
    send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), step);
  endtask

  // Wait until every expected result has come and the block has drained.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Writes all registers back to back; only called while the voice is idle.
  task automatic configure(logic [19:0] frames, logic [19:0] stereo, logic [19:0] ps,
                           logic [19:0] pe, logic [19:0] lb, logic [19:0] lf,
                           logic [19:0] kind, logic [19:0] rate);
    logic [19:0] vals[8];
    vals = '{frames, stereo, ps, pe, lb, lf, kind, rate};
    for (int k = 0; k < 8; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Random register setting. Loops are only enabled while every frame in use is loaded,
  // so no unloaded frame is ever interpolated.
  task automatic random_setting();
    int fr, ps, pe, lb, lf, rate;
    logic [1:0] kind;
    kind = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       rate = 65536;
      1:       rate = 0;
      2:       rate = 20'hFFFFF;
      default: rate = $urandom_range(16384, 180000);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      fr = ($urandom_range(0, 1) == 0) ? MAX_FRAMES : $urandom_range(LOADED + 1, MAX_FRAMES);
      ps = $urandom_range(0, 100);
      pe = ps + $urandom_range(1, 100);
      configure(20'(fr), 20'($urandom_range(0, 1)), 20'(ps), 20'(pe),
                20'($urandom_range(0, 65535)), 20'd0, 20'(kind), 20'(rate));
    end else begin
      fr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(2, LOADED);
      lb = $urandom_range(0, fr);
      lf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, fr + 4) : $urandom_range(lb, fr);
      ps = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, fr);
      pe = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65536) : $urandom_range(0, fr);
      configure(20'(fr), 20'($urandom_range(0, 1)), 20'(ps), 20'(pe), 20'(lb), 20'(lf),
                20'(kind), 20'(rate));
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_LOAD;
    cfg_write = 1'b0;
    cfg_index = REG_FRAMES_IN_USE;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A voice fresh out of reset is done.
    tick(20'h10000);

    // Fill the frames that playback reads, plus the top entry of the store.
    for (int k = 0; k < LOADED; k++) load(16'(k));
    load(16'hFFFF);
    settle();

    // Too few frames.
    configure(20'd1, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'(LOOP_NONE), 20'd65536);
    start(16'd0);
    tick(20'h10000);
    settle();

    // Plain stereo playback, lowest and clamped start fraction, running off the end.
    configure(20'(LOADED), 20'd1, 20'd0, 20'd0, 20'd0, 20'd0, 20'(LOOP_NONE), 20'd65536);
    start(16'd0);
    repeat (3) tick(20'h18000);
    start(16'hFFFF);
    repeat (2) tick(20'h10000);
    settle();

    // Mono with the region end beyond the frame count, then a start past the end.
    configure(20'(LOADED), 20'd0, 20'd10, 20'd65536, 20'd0, 20'd0, 20'(LOOP_NONE),
              20'd65536);
    start(16'h8000);
    tick(20'h0C000);
    settle();
    configure(20'(LOADED), 20'd1, 20'd65535, 20'd0, 20'd0, 20'd0, 20'(LOOP_NONE), 20'd65536);
    start(16'h1234);
    tick(20'h10000);
    settle();

    // Forward wrap at the largest step and rate.
    configure(20'(LOADED), 20'd1, 20'd0, 20'd0, 20'd4, 20'd20, 20'(LOOP_FORWARD), 20'hFFFFF);
    start(16'd100);
    repeat (2) tick(20'hFFFFF);
    settle();

    // Ping-pong reflecting at both loop ends.
    configure(20'(LOADED), 20'd0, 20'd0, 20'd0, 20'd4, 20'd20, 20'(LOOP_PINGPONG),
              20'd65536);
    start(16'd3000);
    repeat (3) tick(20'hFFFFF);
    settle();

    // Sustain until release, then play out.
    configure(20'(LOADED), 20'd1, 20'd0, 20'd0, 20'd2, 20'd9, 20'(LOOP_SUSTAIN), 20'd65536);
    start(16'd9000);
    tick(20'h40000);
    release_key();
    repeat (2) tick(20'hFFFFF);
    settle();

    // Whole store in use with a short region and a zero rate.
    configure(20'd65536, 20'd0, 20'd3, 20'd8, 20'd0, 20'd0, 20'(LOOP_NONE), 20'd0);
    start(16'hFFFF);
    tick(20'hFFFFF);
    settle();

    // Random phases: a fresh setting, then a start followed mostly by ticks.
    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      random_setting();
      start(16'($urandom));
      repeat ($urandom_range(6, 24)) begin
        case ($urandom_range(0, 99)) inside
          [0:74]:  tick(rand_step());
          [75:82]: release_key();
          [83:92]: load(($urandom_range(0, 19) == 0) ? 16'hFFFF :
                        16'($urandom_range(0, LOADED - 1)));
          default: start(16'($urandom));
        endcase
      end
      settle();
    end
    calm = 1'b0;

    $display("Ran %0d loads, %0d starts, %0d releases and %0d ticks across %0d settings;",
             n_load, n_start, n_release, n_tick, n_settings);
    $display("%0d result transactions were compared.", checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lspv_pkg.sv
rtl/lspv_ram.sv
rtl/lspv_front.sv
rtl/lspv_back.sv
rtl/looping_sample_playback_voice.sv
rtl/lspv_checker.sv
tb/voice_checker.sv
tb/tb_top.sv
